>>> rtl/nrbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrbh_pkg
// Shared constants for the nearest ray/box hit block: fixed-point format,
// field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package nrbh_pkg;

  // Q16.16 fraction bits of every coordinate and distance
  localparam int FRAC_BITS = 16;

  // Fixed field widths
  localparam int ID_W     = 10;
  localparam int DIST_W   = 32;
  localparam int REG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RECIP_DIR_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RECIP_DIR_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RECIP_DIR_Z = 3'd5;

endpackage

>>> rtl/nearest_ray_box_hit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_ray_box_hit_top
// Slab test of a stream of axis-aligned boxes against one configured ray,
// keeping the nearest intersected box of each scene.
// ----------------------------------------------------------------------------
// Load the ray (origin and reciprocal direction, signed Q16.16) through the
// configuration port while the block is idle, then stream boxes one per
// clock. Each box passes a five-register pipeline: input capture, corner
// minus origin, the six slab multiplies, floor shift with saturation and
// per-axis sort, and the interval intersection; the last step compares the
// entry distance with the running best. The scene result enters the
// output register when the box marked last_box leaves stage 4. Boxes are
// taken every cycle; in_stall rises only while a scene result reaches the
// output register and the previous result there is still stalled. The six
// multipliers of (COORD_BITS+1) by COORD_BITS bits set the clock period.
// ----------------------------------------------------------------------------
module nearest_ray_box_hit_top
  import nrbh_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,

  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [REG_IDX_W-1:0]         cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,

  // box input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] box_min_x,
  input  logic signed [COORD_BITS-1:0] box_min_y,
  input  logic signed [COORD_BITS-1:0] box_min_z,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] box_max_z,
  input  logic [ID_W-1:0]              box_id,
  input  logic                         last_box,

  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         any_hit,
  output logic [ID_W-1:0]              nearest_id,
  output logic signed [DIST_W-1:0]     nearest_distance
);

  localparam int W  = COORD_BITS;
  localparam int DW = W + 1;             // corner minus origin
  localparam int PW = DW + W;            // exact product
  localparam int TW = PW - W - FRAC_BITS + 1;  // sign bit of the kept result and the bits above it

  localparam logic signed [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] RECIP_ONE = W'(64'd1 << FRAC_BITS);

  // Floor the Q33.32 product to Q16.16 and saturate to the coordinate range
  function automatic logic signed [W-1:0] floor_sat(input logic signed [PW-1:0] p);
    logic [TW-1:0] top;
    top = p[PW-1:W-1+FRAC_BITS];
    if ((&top) || !(|top)) begin
      return p[W-1+FRAC_BITS:FRAC_BITS];
    end else if (p[PW-1]) begin
      return T_MIN;
    end else begin
      return T_MAX;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [W-1:0] origin [3];
  logic signed [W-1:0] rdir   [3];

  assign cfg_ready = 1'b1;

  // write the addressed register; drop indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        origin[a] <= '0;
        rdir[a]   <= RECIP_ONE;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:    origin[0] <= cfg_data;
        REG_ORIGIN_Y:    origin[1] <= cfg_data;
        REG_ORIGIN_Z:    origin[2] <= cfg_data;
        REG_RECIP_DIR_X: rdir[0]   <= cfg_data;
        REG_RECIP_DIR_Y: rdir[1]   <= cfg_data;
        REG_RECIP_DIR_Z: rdir[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic            en;
  logic            v0, v1, v2, v3, v4;
  logic            last0, last1, last2, last3, last4;
  logic [ID_W-1:0] id0, id1, id2, id3, id4;

  // freeze only when a scene result would overwrite a stalled one
  assign en       = !(v4 && last4 && out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // carry id and scene marker alongside the data
  always_ff @(posedge clk) begin
    if (en) begin
      id0   <= box_id;
      last0 <= last_box;
      id1   <= id0;
      last1 <= last0;
      id2   <= id1;
      last2 <= last1;
      id3   <= id2;
      last3 <= last2;
      id4   <= id3;
      last4 <= last3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: capture box corners
  // --------------------------------------------------------------------------
  logic signed [W-1:0] lo0 [3];
  logic signed [W-1:0] hi0 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      lo0[0] <= box_min_x;
      lo0[1] <= box_min_y;
      lo0[2] <= box_min_z;
      hi0[0] <= box_max_x;
      hi0[1] <= box_max_y;
      hi0[2] <= box_max_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: corner minus origin, exact in one extra bit
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] dlo1 [3];
  logic signed [DW-1:0] dhi1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        dlo1[a] <= DW'(lo0[a]) - DW'(origin[a]);
        dhi1[a] <= DW'(hi0[a]) - DW'(origin[a]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: slab multiplies
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] plo2 [3];
  logic signed [PW-1:0] phi2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        plo2[a] <= PW'(dlo1[a]) * PW'(rdir[a]);
        phi2[a] <= PW'(dhi1[a]) * PW'(rdir[a]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: floor shift, saturate, sort entry and exit per axis
  // --------------------------------------------------------------------------
  logic signed [W-1:0] ta_next [3];
  logic signed [W-1:0] tb_next [3];
  logic signed [W-1:0] ta3 [3];
  logic signed [W-1:0] tb3 [3];

  always_comb begin
    logic signed [W-1:0] t_lo;
    logic signed [W-1:0] t_hi;
    for (int a = 0; a < 3; a++) begin
      t_lo = floor_sat(plo2[a]);
      t_hi = floor_sat(phi2[a]);
      if (t_lo > t_hi) begin
        ta_next[a] = t_hi;
        tb_next[a] = t_lo;
      end else begin
        ta_next[a] = t_lo;
        tb_next[a] = t_hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ta3[a] <= ta_next[a];
        tb3[a] <= tb_next[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: intersect the three intervals
  // --------------------------------------------------------------------------
  logic signed [W-1:0] tmin_next;
  logic signed [W-1:0] tmax_next;
  logic signed [W-1:0] tmin4;
  logic                hit4;

  always_comb begin
    tmin_next = (ta3[0] > ta3[1]) ? ta3[0] : ta3[1];
    if (ta3[2] > tmin_next) begin
      tmin_next = ta3[2];
    end
    tmax_next = (tb3[0] < tb3[1]) ? tb3[0] : tb3[1];
    if (tb3[2] < tmax_next) begin
      tmax_next = tb3[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tmin4 <= tmin_next;
      hit4  <= !(tmin_next > tmax_next);
    end
  end

  // --------------------------------------------------------------------------
  // Running best and scene result
  // --------------------------------------------------------------------------
  logic signed [W-1:0] best_distance;
  logic [ID_W-1:0]     best_id;
  logic                have_hit;
  logic                take;
  logic signed [W-1:0] best_distance_next;
  logic [ID_W-1:0]     best_id_next;
  logic                have_hit_next;
  logic                emit;

  // first hit of a scene always wins; later ones only when strictly nearer
  always_comb begin
    take               = hit4 && (!have_hit || (tmin4 < best_distance));
    best_distance_next = take ? tmin4 : best_distance;
    best_id_next       = take ? id4 : best_id;
    have_hit_next      = have_hit || take;
    emit               = en && v4 && last4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= T_MAX;
      best_id       <= '0;
      have_hit      <= 1'b0;
    end else if (en && v4) begin
      if (last4) begin
        best_distance <= T_MAX;
        best_id       <= '0;
        have_hit      <= 1'b0;
      end else begin
        best_distance <= best_distance_next;
        best_id       <= best_id_next;
        have_hit      <= have_hit_next;
      end
    end
  end

  // hold the result until taken; load a new one at the end of a scene
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      any_hit          <= have_hit_next;
      nearest_id       <= have_hit_next ? best_id_next : '0;
      nearest_distance <= have_hit_next ? DIST_W'(best_distance_next) : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // running state is cleared once a scene result is issued
  a_clear_after_scene: assert property (@(posedge clk) disable iff (rst)
    emit |=> (!have_hit && best_id == '0))
    else $error("running best not cleared after scene end");

  // no hit recorded means the kept id is still its cleared value
  a_idle_best_id: assert property (@(posedge clk) disable iff (rst)
    !have_hit |-> best_id == '0)
    else $error("best id set without a recorded hit");

  // a result without a hit carries zero id and distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !any_hit) |-> (nearest_id == '0 && nearest_distance == '0))
    else $error("miss result carries nonzero id or distance");

  // the input side only stalls while a stalled result blocks a new one
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v4 && last4 && out_valid))
    else $error("input stalled without a pending scene result");
`endif

endmodule

>>> tb/tb_nearest_ray_box_hit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_ray_box_hit_top
// Streams scenes of axis-aligned boxes through the block under a series of
// ray settings and checks every scene outcome (hit flag, nearest id, entry
// distance) against an in-bench slab-test predictor. Both channels idle and
// stall at random; one phase runs with no idling.
// ----------------------------------------------------------------------------
module tb_nearest_ray_box_hit_top;
  import nrbh_pkg::*;

  localparam int COORD_W = 32;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = REG_RECIP_DIR_Z + 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = REG_RECIP_DIR_Z + 3'd2;
  localparam logic signed [COORD_W-1:0] SAT_HI = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] SAT_LO = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] ONE_Q16 = COORD_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [COORD_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
    logic [ID_W-1:0]    id;
    logic               last;
  } box_t;

  typedef struct packed {
    logic              hit;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
  } scene_outcome_t;

  logic clk;
  logic rst = 1'b1;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [REG_IDX_W-1:0]         cfg_index = '0;
  logic [COORD_W-1:0]           cfg_data = '0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [COORD_W-1:0]    box_min_x = '0;
  logic signed [COORD_W-1:0]    box_min_y = '0;
  logic signed [COORD_W-1:0]    box_min_z = '0;
  logic signed [COORD_W-1:0]    box_max_x = '0;
  logic signed [COORD_W-1:0]    box_max_y = '0;
  logic signed [COORD_W-1:0]    box_max_z = '0;
  logic [ID_W-1:0]              box_id = '0;
  logic                         last_box = 1'b0;

  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         any_hit;
  logic [ID_W-1:0]              nearest_id;
  logic signed [DIST_W-1:0]     nearest_distance;

  // Predictor state: ray registers and the running scene best
  logic signed [COORD_W-1:0] ray_start [3];
  logic signed [COORD_W-1:0] ray_recip [3];
  logic signed [COORD_W-1:0] scene_best;
  logic [ID_W-1:0]           scene_best_id;
  logic                      scene_hit;

  box_t           pending_boxes [$];
  scene_outcome_t scene_results [$];
  box_t           current_box;
  box_t           prior_box;
  scene_outcome_t want;
  int             boxes_queued = 0;
  int             boxes_taken = 0;
  int             failures = 0;
  int             idle_pct = 33;

  nearest_ray_box_hit_top #(
    .COORD_BITS(COORD_W)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .box_min_x        (box_min_x),
    .box_min_y        (box_min_y),
    .box_min_z        (box_min_z),
    .box_max_x        (box_max_x),
    .box_max_y        (box_max_y),
    .box_max_z        (box_max_z),
    .box_id           (box_id),
    .last_box         (last_box),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .any_hit          (any_hit),
    .nearest_id       (nearest_id),
    .nearest_distance (nearest_distance)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Slab value: exact (corner - origin) * recip, floor shift, saturate
  function automatic logic signed [COORD_W-1:0] slab_distance(
    input logic signed [COORD_W-1:0] corner,
    input logic signed [COORD_W-1:0] origin,
    input logic signed [COORD_W-1:0] recip
  );
    logic signed [COORD_W:0]     gap;
    logic signed [2*COORD_W+1:0] prod;
    logic signed [2*COORD_W+1:0] shifted;
    gap = corner - origin;
    prod = gap * recip;
    shifted = prod >>> FRAC_BITS;
    if (shifted > SAT_HI) return SAT_HI;
    if (shifted < SAT_LO) return SAT_LO;
    return shifted[COORD_W-1:0];
  endfunction

  // Run the slab test on one accepted box; emit the scene outcome on last
  task automatic trace_box(input box_t b);
    logic signed [COORD_W-1:0] lo, hi, swap, t_in, t_out;
    logic [COORD_W-1:0]        lo_c [3];
    logic [COORD_W-1:0]        hi_c [3];
    logic                      crossed;
    scene_outcome_t            outcome;
    lo_c[0] = b.min_x; lo_c[1] = b.min_y; lo_c[2] = b.min_z;
    hi_c[0] = b.max_x; hi_c[1] = b.max_y; hi_c[2] = b.max_z;
    crossed = 1'b1;
    t_in = '0;
    t_out = '0;
    for (int ax = 0; ax < 3; ax++) begin
      lo = slab_distance(lo_c[ax], ray_start[ax], ray_recip[ax]);
      hi = slab_distance(hi_c[ax], ray_start[ax], ray_recip[ax]);
      if (lo > hi) begin
        swap = lo;
        lo = hi;
        hi = swap;
      end
      if (ax == 0) begin
        t_in = lo;
        t_out = hi;
      end else if (t_in > hi || lo > t_out) begin
        crossed = 1'b0;
      end else begin
        if (lo > t_in) t_in = lo;
        if (hi < t_out) t_out = hi;
      end
    end
    // first hit of a scene always taken, later ones only when strictly nearer
    if (crossed && (!scene_hit || t_in < scene_best)) begin
      scene_best = t_in;
      scene_best_id = b.id;
      scene_hit = 1'b1;
    end
    if (b.last) begin
      outcome.hit = scene_hit;
      outcome.id = scene_hit ? scene_best_id : '0;
      outcome.distance = scene_hit ? scene_best : '0;
      scene_results.push_back(outcome);
      scene_best = SAT_HI;
      scene_best_id = '0;
      scene_hit = 1'b0;
    end
  endtask

  // Write one ray register; caller lowers cfg_valid after the last write
  task automatic write_ray_reg(input logic [REG_IDX_W-1:0] idx,
                               input logic [COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIGIN_X:    ray_start[0] = data;
      REG_ORIGIN_Y:    ray_start[1] = data;
      REG_ORIGIN_Z:    ray_start[2] = data;
      REG_RECIP_DIR_X: ray_recip[0] = data;
      REG_RECIP_DIR_Y: ray_recip[1] = data;
      REG_RECIP_DIR_Z: ray_recip[2] = data;
      default: ;
    endcase
  endtask

  task automatic program_ray(input logic [COORD_W-1:0] o [3],
                             input logic [COORD_W-1:0] r [3]);
    for (int ax = 0; ax < 3; ax++)
      write_ray_reg(REG_IDX_W'(REG_ORIGIN_X + ax), o[ax]);
    for (int ax = 0; ax < 3; ax++)
      write_ray_reg(REG_IDX_W'(REG_RECIP_DIR_X + ax), r[ax]);
    // unmapped index must leave the ray alone
    write_ray_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_ray(input bit extreme);
    logic [COORD_W-1:0] o [3];
    logic [COORD_W-1:0] r [3];
    for (int ax = 0; ax < 3; ax++) begin
      if (extreme) begin
        case ($urandom_range(3))
          0: o[ax] = SAT_HI;
          1: o[ax] = SAT_LO;
          2: o[ax] = '0;
          default: o[ax] = $urandom;
        endcase
        case ($urandom_range(3))
          0: r[ax] = SAT_HI;
          1: r[ax] = SAT_LO;
          2: r[ax] = '0;
          default: r[ax] = ONE_Q16;
        endcase
      end else begin
        o[ax] = $urandom_range(0, 1 << 25) - (1 << 24);
        r[ax] = $urandom_range(1 << 12, 1 << 20);
        if ($urandom_range(1)) r[ax] = -r[ax];
        if ($urandom_range(19) == 0) r[ax] = '0;
      end
    end
    program_ray(o, r);
  endtask

  function automatic logic [COORD_W-1:0] to_q16(input int v);
    return COORD_W'(v) << FRAC_BITS;
  endfunction

  function automatic box_t make_box(
    input logic [COORD_W-1:0] nx, ny, nz, xx, xy, xz,
    input logic [ID_W-1:0] id, input logic last
  );
    box_t b;
    b.min_x = nx; b.min_y = ny; b.min_z = nz;
    b.max_x = xx; b.max_y = xy; b.max_z = xz;
    b.id = id;
    b.last = last;
    return b;
  endfunction

  task automatic queue_box(input box_t b);
    pending_boxes.push_back(b);
    boxes_queued++;
  endtask

  // Mostly boxes placed along the ray, plus noise and near-origin boxes
  function automatic box_t random_box(input logic last);
    box_t               b;
    logic [COORD_W-1:0] lo [3];
    logic [COORD_W-1:0] hi [3];
    logic [COORD_W-1:0] swap;
    longint             t0, span, centre, half;
    int                 mode;
    mode = $urandom_range(99);
    t0 = longint'($urandom_range(0, 400 << FRAC_BITS)) - (longint'(200) << FRAC_BITS);
    for (int ax = 0; ax < 3; ax++) begin
      half = $urandom_range(1, 1 << 20);
      if (mode < 60) begin
        if (ray_recip[ax] == 0) begin
          centre = longint'(ray_start[ax]);
        end else begin
          span = (longint'(1) <<< 32) / longint'(ray_recip[ax]);
          centre = longint'(ray_start[ax]) + ((t0 * span) >>> FRAC_BITS);
        end
        lo[ax] = COORD_W'(centre - half);
        hi[ax] = COORD_W'(centre + half);
      end else if (mode < 80) begin
        lo[ax] = $urandom;
        hi[ax] = $urandom;
      end else begin
        centre = longint'(ray_start[ax]) + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        lo[ax] = COORD_W'(centre - half);
        hi[ax] = COORD_W'(centre + half);
      end
      if ($urandom_range(6) == 0) begin
        swap = lo[ax];
        lo[ax] = hi[ax];
        hi[ax] = swap;
      end
    end
    b = make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                 ID_W'($urandom_range(1023)), last);
    // repeat the previous box under a new id to hit distance ties
    if ($urandom_range(9) == 0) begin
      b.min_x = prior_box.min_x; b.min_y = prior_box.min_y; b.min_z = prior_box.min_z;
      b.max_x = prior_box.max_x; b.max_y = prior_box.max_y; b.max_z = prior_box.max_z;
    end
    prior_box = b;
    return b;
  endfunction

  task automatic run_random_phase(input int n_boxes);
    int count, len;
    count = 0;
    while (count < n_boxes) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        queue_box(random_box(i == len - 1));
      count += len;
    end
  endtask

  // Wait until every box is taken and every outcome seen, then let the pipe empty
  task automatic wait_drained();
    do @(posedge clk); while (boxes_taken != boxes_queued || scene_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Box driver: hold the item while stalled, advance on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        trace_box(current_box);
        boxes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_boxes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          current_box = pending_boxes.pop_front();
          box_min_x <= current_box.min_x;
          box_min_y <= current_box.min_y;
          box_min_z <= current_box.min_z;
          box_max_x <= current_box.max_x;
          box_max_y <= current_box.max_y;
          box_max_z <= current_box.max_z;
          box_id <= current_box.id;
          last_box <= current_box.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Outcome monitor: compare each accepted item with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (scene_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected outcome: hit=%0b id=%0d dist=%0d",
                     any_hit, nearest_id, nearest_distance);
        end else begin
          want = scene_results.pop_front();
          if (any_hit !== want.hit || nearest_id !== want.id ||
              nearest_distance !== want.distance) begin
            failures++;
            if (failures <= 10)
              $display("outcome mismatch: expected hit=%0b id=%0d dist=%0d, got hit=%0b id=%0d dist=%0d",
                       want.hit, want.id, $signed(want.distance),
                       any_hit, nearest_id, nearest_distance);
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("tb_nearest_ray_box_hit_top NOT OK");
    $finish;
  end

  initial begin
    logic [COORD_W-1:0] o [3];
    logic [COORD_W-1:0] r [3];
    for (int ax = 0; ax < 3; ax++) begin
      ray_start[ax] = '0;
      ray_recip[ax] = ONE_Q16;
    end
    scene_best = SAT_HI;
    scene_best_id = '0;
    scene_hit = 1'b0;
    prior_box = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed scenes under the reset ray (origin 0, unit reciprocals)
    // miss: x and y slabs disjoint, outcome is all zero
    queue_box(make_box(to_q16(10), to_q16(0), to_q16(0),
                       to_q16(20), to_q16(1), to_q16(1), 10'd5, 1'b1));
    // box straddling the origin: negative entry distance kept
    queue_box(make_box(to_q16(-5), to_q16(-5), to_q16(-5),
                       to_q16(5), to_q16(5), to_q16(5), 10'd1023, 1'b1));
    // equal distances: first box wins
    queue_box(make_box(to_q16(1), to_q16(1), to_q16(1),
                       to_q16(3), to_q16(3), to_q16(3), 10'd7, 1'b0));
    queue_box(make_box(to_q16(1), to_q16(1), to_q16(1),
                       to_q16(3), to_q16(3), to_q16(3), 10'd9, 1'b1));
    // nearer box later in the scene replaces the first
    queue_box(make_box(to_q16(4), to_q16(4), to_q16(4),
                       to_q16(6), to_q16(6), to_q16(6), 10'd3, 1'b0));
    queue_box(make_box(to_q16(2), to_q16(2), to_q16(2),
                       to_q16(8), to_q16(8), to_q16(8), 10'd4, 1'b1));
    // inverted corners
    queue_box(make_box(to_q16(6), to_q16(6), to_q16(6),
                       to_q16(2), to_q16(2), to_q16(2), 10'd12, 1'b1));
    // full coordinate range, id zero
    queue_box(make_box(SAT_LO, SAT_LO, SAT_LO, SAT_HI, SAT_HI, SAT_HI, 10'd0, 1'b1));
    // first hit at the largest distance is taken, an equal one is not
    queue_box(make_box(SAT_HI, SAT_HI, SAT_HI, SAT_HI, SAT_HI, SAT_HI, 10'd100, 1'b0));
    queue_box(make_box(SAT_HI, SAT_HI, SAT_HI, SAT_HI, SAT_HI, SAT_HI, 10'd101, 1'b0));
    queue_box(make_box(to_q16(10), to_q16(0), to_q16(0),
                       to_q16(20), to_q16(1), to_q16(1), 10'd102, 1'b1));
    wait_drained();

    // Extreme ray: saturating products and a zero reciprocal
    o[0] = SAT_HI; o[1] = SAT_LO; o[2] = '0;
    r[0] = SAT_HI; r[1] = SAT_LO; r[2] = '0;
    program_ray(o, r);
    queue_box(make_box(SAT_LO, SAT_LO, SAT_LO, SAT_HI, SAT_HI, SAT_HI, 10'd1, 1'b1));
    queue_box(make_box(SAT_HI, SAT_LO, to_q16(-1), SAT_HI, SAT_LO, to_q16(1),
                       10'd2, 1'b1));
    queue_box(make_box(to_q16(3), to_q16(-3), to_q16(0),
                       to_q16(4), to_q16(-2), to_q16(2), 10'd512, 1'b1));
    for (int i = 0; i < 4; i++)
      queue_box(make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         ID_W'($urandom_range(1023)), i == 3));
    wait_drained();

    // Random scenes over several ray settings
    for (int p = 0; p < 6; p++) begin
      idle_pct = (p == 1) ? 0 : 33;
      load_random_ray(p == 2 || p == 4);
      run_random_phase(250);
      wait_drained();
    end

    if (failures == 0) begin
      $display("tb_nearest_ray_box_hit_top OK");
    end else begin
      $display("tb_nearest_ray_box_hit_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/nrbh_pkg.sv
rtl/nearest_ray_box_hit_top.sv
tb/tb_nearest_ray_box_hit_top.sv
